FILE: hdl/bb3_pkg.sv
// Shared types and constants of the 3x3 box blur.
`timescale 1ns / 1ps

package bb3_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int QUEUE_DEPTH       = 4;

   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;
   localparam int FRAME_WIDTH_W      = 11;
   localparam int FRAME_HEIGHT_W     = 12;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // floor(s / 9) == (s * 7282) >> 16 for every nine-pixel sum up to 2295
   localparam int DIV9_RECIP = 7282;
   localparam int DIV9_SHIFT = 16;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [7:0] pixel_blue;
      logic [7:0] pixel_green;
      logic [7:0] pixel_red;
      logic       flush;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       last_of_frame;
   } rsp_word_type;

   // one window column plus what the back end must do with it
   typedef struct packed {
      rgb_type top;
      rgb_type mid;
      rgb_type bot;
      logic    emit;
      logic    interior;
      logic    last;
   } work_type;

endpackage

FILE: hdl/bb3_if.sv
// Stream interfaces for the pixel and result channels.
`timescale 1ns / 1ps

interface bb3_req_if;
   import bb3_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bb3_rsp_if;
   import bb3_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/bb3_front.sv
// Front end: frame position, line stores and classification of each word.
`timescale 1ns / 1ps

module bb3_front import bb3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   bb3_req_if.sink                req_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   push_valid,
   input  logic                   push_ready,
   output work_type               push_word
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = FRAME_HEIGHT_W;
   localparam int IRW = FRAME_HEIGHT_W + 1;
   localparam int RST_W = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
   localparam logic [CW-1:0] RST_WM1 = CW'(RST_W - 1);
   localparam logic [RW-1:0] RST_HM1 = RW'(FRAME_HEIGHT_RESET - 1);

   // width and height minus one, already clamped
   logic [CW-1:0]  wm1_ff;
   logic [RW-1:0]  hm1_ff;
   logic [CW-1:0]  in_col_ff, in_col_in;
   logic [IRW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0]  out_col_ff, out_col_in;
   logic [RW-1:0]  out_row_ff, out_row_in;

   logic           s1_valid_ff, s1_valid_in;
   logic [CW-1:0]  s1_col_ff;
   logic           s1_real_ff;
   rgb_type        s1_pix_ff;
   logic           s1_emit_ff, s1_interior_ff, s1_last_ff;
   rgb_type        rd_upper_ff, rd_middle_ff;

   rgb_type        upper_mem  [MAX_WIDTH];
   rgb_type        middle_mem [MAX_WIDTH];

   logic [FRAME_WIDTH_W-1:0]  csr_fw;
   logic [FRAME_HEIGHT_W-1:0] csr_fh;
   logic [CW-1:0]  wm1_wr;
   logic [RW-1:0]  hm1_wr;

   logic           accept, done, ignore, load, s1_go, wr_en, bypass;
   logic [CW-1:0]  col;
   logic           emit, interior, last;
   rgb_type        pix;

   assign accept   = req_if.valid && req_if.ready;
   assign done     = in_row_ff > {1'b0, hm1_ff};
   assign ignore   = req_if.payload.flush && !done;
   assign load     = accept && !ignore;
   assign col      = (in_col_ff > wm1_ff) ? '0 : in_col_ff;
   assign emit     = (in_row_ff >= IRW'(2)) || ((in_row_ff == IRW'(1)) && (col != '0));
   assign interior = (out_row_ff != '0) && (out_row_ff < hm1_ff) &&
                     (out_col_ff != '0) && (out_col_ff < wm1_ff);
   assign last     = (out_row_ff >= hm1_ff) && (out_col_ff >= wm1_ff);

   assign s1_go        = s1_valid_ff && push_ready;
   assign req_if.ready = !s1_valid_ff || push_ready;
   assign wr_en        = s1_go && s1_real_ff;
   // the word leaving s1 writes the entry this word reads: forward it
   assign bypass       = load && wr_en && (s1_col_ff == col);

   always_comb begin
      pix = '0;
      if (!done) begin
         pix.red   = req_if.payload.pixel_red;
         pix.green = req_if.payload.pixel_green;
         pix.blue  = req_if.payload.pixel_blue;
      end
   end

   assign csr_fw = csr_data[FRAME_WIDTH_W-1:0];
   assign csr_fh = csr_data[FRAME_HEIGHT_W-1:0];

   always_comb begin
      if (csr_fw == '0) begin
         wm1_wr = '0;
      end else if (32'(csr_fw) > 32'(MAX_WIDTH)) begin
         wm1_wr = CW'(MAX_WIDTH - 1);
      end else begin
         wm1_wr = CW'(csr_fw - FRAME_WIDTH_W'(1));
      end
      hm1_wr = (csr_fh == '0) ? '0 : csr_fh - RW'(1);
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_we) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (load) begin
         if (col == wm1_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IRW'(1);
         end else begin
            in_col_in = col + CW'(1);
         end
         if (emit) begin
            if (last) begin
               // frame complete: start over
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff == wm1_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff      <= RST_WM1;
         hm1_ff      <= RST_HM1;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  wm1_ff <= wm1_wr;
               CSR_FRAME_HEIGHT: hm1_ff <= hm1_wr;
               default: ;
            endcase
         end
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_col_ff      <= col;
         s1_real_ff     <= !done;
         s1_pix_ff      <= pix;
         s1_emit_ff     <= emit;
         s1_interior_ff <= interior;
         s1_last_ff     <= last;
      end
   end

   // line stores: read on each loaded word, write back when the word moves on
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[s1_col_ff]  <= rd_middle_ff;
         middle_mem[s1_col_ff] <= s1_pix_ff;
      end
      if (load) begin
         if (bypass) begin
            rd_upper_ff  <= rd_middle_ff;
            rd_middle_ff <= s1_pix_ff;
         end else begin
            rd_upper_ff  <= upper_mem[col];
            rd_middle_ff <= middle_mem[col];
         end
      end
   end

   assign push_valid         = s1_valid_ff;
   assign push_word.top      = rd_upper_ff;
   assign push_word.mid      = rd_middle_ff;
   assign push_word.bot      = s1_pix_ff;
   assign push_word.emit     = s1_emit_ff;
   assign push_word.interior = s1_interior_ff;
   assign push_word.last     = s1_last_ff;

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (in_col_ff <= wm1_ff) && (out_col_ff <= wm1_ff) && (out_row_ff <= hm1_ff))
      else $error("frame position outside the configured frame");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (load && emit && last) |=>
      (in_col_ff == '0) && (in_row_ff == '0) && (out_col_ff == '0) && (out_row_ff == '0))
      else $error("position not cleared after last word of frame");

endmodule

FILE: hdl/bb3_fifo.sv
// Short queue of window columns between front and back end.
`timescale 1ns / 1ps

module bb3_fifo import bb3_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_word,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_word
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   work_type       entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]  count_ff, count_in;
   logic           push, pop;

   assign push_ready = count_ff != NW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_word   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != NW'(DEPTH)) && (count_ff != '0) |->
      (NW'(wr_ptr_ff) == ((NW'(rd_ptr_ff) + count_ff >= NW'(DEPTH)) ?
                          NW'(rd_ptr_ff) + count_ff - NW'(DEPTH) :
                          NW'(rd_ptr_ff) + count_ff)))
      else $error("queue count out of step with pointers");

endmodule

FILE: hdl/bb3_back.sv
// Back end: 3x3 window, nine-pixel sums, divide by nine inside, border kept, result register.
`timescale 1ns / 1ps

module bb3_back import bb3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  work_type pop_word,
   bb3_rsp_if.source rsp_if
);

   typedef struct packed {
      logic [9:0] red;
      logic [9:0] green;
      logic [9:0] blue;
   } csum_type;

   typedef struct packed {
      logic [11:0] red;
      logic [11:0] green;
      logic [11:0] blue;
   } sum_type;

   logic         en, pop;
   csum_type     col_sum;

   // window: three column sums and the center pixel
   csum_type     cs0_ff, cs1_ff, cs2_ff;
   rgb_type      mid2_ff, ctr_ff;
   logic         w_valid_ff, w_interior_ff, w_last_ff;

   sum_type      s_sum_ff;
   rgb_type      s_ctr_ff;
   logic         s_valid_ff, s_interior_ff, s_last_ff;

   logic         o_valid_ff;
   rsp_word_type o_word_ff;

   function automatic logic [9:0] add3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return 10'(a) + 10'(b) + 10'(c);
   endfunction

   function automatic logic [11:0] add3w(input logic [9:0] a, input logic [9:0] b,
                                         input logic [9:0] c);
      return 12'(a) + 12'(b) + 12'(c);
   endfunction

   function automatic logic [7:0] div9(input logic [11:0] s);
      logic [24:0] p;
      p = 25'(s) * 25'(DIV9_RECIP);
      return p[DIV9_SHIFT+7:DIV9_SHIFT];
   endfunction

   // advance the whole back end unless a result waits at the port
   assign en        = !o_valid_ff || rsp_if.ready;
   assign pop_ready = en;
   assign pop       = pop_valid && en;

   assign col_sum.red   = add3(pop_word.top.red,   pop_word.mid.red,   pop_word.bot.red);
   assign col_sum.green = add3(pop_word.top.green, pop_word.mid.green, pop_word.bot.green);
   assign col_sum.blue  = add3(pop_word.top.blue,  pop_word.mid.blue,  pop_word.bot.blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         cs0_ff     <= '0;
         cs1_ff     <= '0;
         cs2_ff     <= '0;
         mid2_ff    <= '0;
         ctr_ff     <= '0;
         w_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         w_valid_ff <= pop && pop_word.emit;
         if (pop) begin
            cs0_ff  <= cs1_ff;
            cs1_ff  <= cs2_ff;
            cs2_ff  <= col_sum;
            ctr_ff  <= mid2_ff;
            mid2_ff <= pop_word.mid;
         end
         s_valid_ff <= w_valid_ff;
         o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (pop) begin
            w_interior_ff <= pop_word.interior;
            w_last_ff     <= pop_word.last;
         end
         s_sum_ff.red   <= add3w(cs0_ff.red,   cs1_ff.red,   cs2_ff.red);
         s_sum_ff.green <= add3w(cs0_ff.green, cs1_ff.green, cs2_ff.green);
         s_sum_ff.blue  <= add3w(cs0_ff.blue,  cs1_ff.blue,  cs2_ff.blue);
         s_ctr_ff       <= ctr_ff;
         s_interior_ff  <= w_interior_ff;
         s_last_ff      <= w_last_ff;
         if (s_interior_ff) begin
            o_word_ff.out_red   <= div9(s_sum_ff.red);
            o_word_ff.out_green <= div9(s_sum_ff.green);
            o_word_ff.out_blue  <= div9(s_sum_ff.blue);
         end else begin
            o_word_ff.out_red   <= s_ctr_ff.red;
            o_word_ff.out_green <= s_ctr_ff.green;
            o_word_ff.out_blue  <= s_ctr_ff.blue;
         end
         o_word_ff.last_of_frame <= s_last_ff;
      end
   end

   assign rsp_if.valid   = o_valid_ff;
   assign rsp_if.payload = o_word_ff;

   a_last_not_interior: assert property (@(posedge clock) disable iff (reset)
      w_valid_ff |-> !(w_interior_ff && w_last_ff))
      else $error("last pixel of frame classified as interior");

endmodule

FILE: hdl/box_blur_3x3_rgb_top.sv
// Top level of the streaming 3x3 box blur for RGB pixels.
//
//   port group  dir  handshake          word
//   req_if      in   valid/ready        pixel_blue, pixel_green, pixel_red, flush
//   rsp_if      out  valid/ready        out_blue, out_green, out_red, last_of_frame
//   csr_*       in   csr_we, no wait    csr_index selects frame_width/frame_height
//
// One word per clock while rsp_if is not stalled; the line stores take one read
// and one write per word, which sets that rate. A result passes s1, the queue
// and window, sum and output regs; a frame's result k needs input word k + width + 1.
// Reset is synchronous; the line stores are not cleared.
// A stalled result port holds the output register and the whole back end; the
// four-entry queue then fills before req_if.ready drops.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_top import bb3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   bb3_req_if.sink                req_if,
   bb3_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic     push_valid, push_ready;
   work_type push_word;
   logic     pop_valid, pop_ready;
   work_type pop_word;

   bb3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   bb3_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   bb3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_word  (pop_word),
      .rsp_if    (rsp_if)
   );

endmodule
